FILE: rtl/fsas_pkg.sv
// shared constants for the float scatter-add store: request kinds, register
// indexes and float32 field widths. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fsas_pkg;

   localparam int STORE_DEPTH_DEF = 4096;
   localparam int FP_W            = 32;
   localparam int LEN_W           = 13;
   localparam int CSR_IDX_W       = 8;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_ACC  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam logic [1:0] REQ_RSVD = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDS_CHECK = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRAY_LENGTH = 8'd1;

   localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [FP_W-1:0] POS_INF   = 32'h7F80_0000;
   localparam logic [FP_W-1:0] QUIET_BIT = 32'h0040_0000;

endpackage
`default_nettype wire

FILE: rtl/float_scatter_add_store_top.sv
// float scatter-add store: a ram of float32 entries served by load, add and
// read requests, with a config write channel. uses fsas_pkg, fsas_ram, fsas_fadd.
//
// req channel: tdata = {operand_bits, index}, tuser = request kind
// (0 load, 1 add, 2 read), tlast marks the end of a batch. rsp channel: one item
// per request, tdata = entry after the request (0 if the index is out of
// range), tuser = range error, tlast copied from the request.
// csr channel: index 0 bounds check enable, index 1 array length; always ready,
// to be written only while the block is idle; the block does not enforce it.
// one request is worked on at a time; req_tready is high only while idle.
// path from an accepted request to the response register: load or out of range
// go straight to ST_DONE; read goes ST_READ, ST_DATA, ST_DONE; add goes
// ST_READ, ST_DATA, ST_ADD, ST_DONE and waits in ST_ADD for the adder, which
// skips to its finish step when an operand is zero, infinite or nan and
// otherwise runs its one-bit-per-cycle alignment and normalization steps. a new
// request is taken once the response register loads, even while a response still
// waits; a stalled rsp side holds the next result in its last step until the
// response register frees. reset clears the state, the csr registers and the
// response valid flag; ram entries stay undefined until loaded, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module float_scatter_add_store_top #(
   parameter int STORE_DEPTH = fsas_pkg::STORE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // index[31:0], operand_bits[63:32]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // word_bits[31:0]
   output logic             rsp_tuser,   // range_error
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [fsas_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fsas_pkg::LEN_W-1:0]     csr_data
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [31:0] DEPTH32 = 32'(STORE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DATA, ST_ADD, ST_DONE
   } state_type;

   state_type state_ff;
   logic                          bce_ff;
   logic [fsas_pkg::LEN_W-1:0]    len_ff;
   logic [1:0]                    kind_ff;
   logic [AW-1:0]                 addr_ff;
   logic [31:0]                   op_ff, word_ff;
   logic                          inrange_ff, last_ff;
   logic [31:0]                   rsp_data_ff;
   logic                          rsp_valid_ff, rsp_err_ff, rsp_last_ff;

   logic [31:0] len_eff, idx;
   logic        in_range, out_free, fadd_start, fadd_done, wr_en;
   logic [31:0] rd_data, fadd_res;

   assign idx      = req_tdata[31:0];
   assign len_eff  = ({19'd0, len_ff} > DEPTH32) ? DEPTH32 : {19'd0, len_ff};
   assign in_range = !idx[31] && (idx < len_eff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign fadd_start = (state_ff == ST_DATA) && (kind_ff == fsas_pkg::REQ_ACC);
   assign wr_en = (state_ff == ST_DONE) && out_free && inrange_ff &&
                  ((kind_ff == fsas_pkg::REQ_LOAD) || (kind_ff == fsas_pkg::REQ_ACC));

   fsas_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (word_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   fsas_fadd u_fadd (
      .clock  (clock),
      .reset  (reset),
      .start  (fadd_start),
      .a      (rd_data),
      .b      (op_ff),
      .done   (fadd_done),
      .result (fadd_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bce_ff       <= 1'b0;
         len_ff       <= 13'd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               fsas_pkg::CSR_BOUNDS_CHECK: bce_ff <= csr_data[0];
               fsas_pkg::CSR_ARRAY_LENGTH: len_ff <= csr_data;
               default: ;
            endcase
         end
         // a result leaving ST_DONE refills the register in the same cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff    <= req_tuser;
                  addr_ff    <= idx[AW-1:0];
                  op_ff      <= req_tdata[63:32];
                  last_ff    <= req_tlast;
                  inrange_ff <= in_range;
                  if (!in_range) begin
                     word_ff  <= 32'd0;
                     state_ff <= ST_DONE;
                  end else if (req_tuser == fsas_pkg::REQ_LOAD) begin
                     word_ff  <= req_tdata[63:32];
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: state_ff <= ST_DATA;
            ST_DATA: begin
               case (kind_ff)
                  fsas_pkg::REQ_ACC: state_ff <= ST_ADD;
                  default: begin
                     word_ff  <= rd_data;
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_ADD: begin
               if (fadd_done) begin
                  word_ff  <= fadd_res;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= word_ff;
                  rsp_err_ff   <= !inrange_ff && bce_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

FILE: rtl/fsas_ram.sv
// generic single-write, single-read ram with registered read data.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fsas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/fsas_fadd.sv
// iterative float32 adder: one-bit alignment and normalization shift steps,
// round-to-nearest-even. uses fsas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsas_fadd (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [fsas_pkg::FP_W-1:0] a,
   input  wire logic [fsas_pkg::FP_W-1:0] b,
   output logic                          done,
   output logic      [fsas_pkg::FP_W-1:0] result
);

   typedef enum logic [2:0] {
      S_IDLE, S_ALIGN, S_ADD, S_NORM, S_ROUND, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [26:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [27:0]        m_ff, m_in;
   logic [9:0]         ex_ff, ex_in;
   logic [4:0]         diff_ff, diff_in;
   logic               sign_ff, sign_in, sub_ff, sub_in;
   logic [31:0]        res_ff, res_in;

   logic               sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [7:0]         ea, eb, ea_e, eb_e, dexp;
   logic [23:0]        fa, fb;
   logic               swap;
   logic [27:0]        sum;
   logic [23:0]        q;
   logic               inc;
   logic [32:0]        r;

   assign sa     = a[31];
   assign sb     = b[31];
   assign ea     = a[30:23];
   assign eb     = b[30:23];
   assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
   assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
   assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
   assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
   assign a_zero = (a[30:0] == 31'd0);
   assign b_zero = (b[30:0] == 31'd0);
   assign fa     = {(ea != 8'd0), a[22:0]};
   assign fb     = {(eb != 8'd0), b[22:0]};
   assign ea_e   = (ea == 8'd0) ? 8'd1 : ea;
   assign eb_e   = (eb == 8'd0) ? 8'd1 : eb;
   assign swap   = {eb_e, fb} > {ea_e, fa};
   assign dexp   = swap ? (eb_e - ea_e) : (ea_e - eb_e);

   assign sum = sub_ff ? ({1'b0, ma_ff} - {1'b0, mb_ff}) : ({1'b0, ma_ff} + {1'b0, mb_ff});
   assign q   = m_ff[26:3];
   assign inc = (m_ff[2:0] > 3'd4) || ((m_ff[2:0] == 3'd4) && q[0]);
   assign r   = ({23'd0, ex_ff - 10'd1} << 23) + {9'd0, q} + {32'd0, inc};

   always_comb begin
      state_in = state_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      m_in     = m_ff;
      ex_in    = ex_ff;
      diff_in  = diff_ff;
      sign_in  = sign_ff;
      sub_in   = sub_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_FIN;
               if (a_nan) begin
                  res_in = a | fsas_pkg::QUIET_BIT;
               end else if (b_nan) begin
                  res_in = b | fsas_pkg::QUIET_BIT;
               end else if (a_inf) begin
                  res_in = (b_inf && (sa != sb)) ? fsas_pkg::CANON_NAN : a;
               end else if (b_inf) begin
                  res_in = b;
               end else if (a_zero && b_zero) begin
                  res_in = {sa & sb, 31'd0};
               end else if (a_zero) begin
                  res_in = b;
               end else if (b_zero) begin
                  res_in = a;
               end else begin
                  state_in = S_ALIGN;
                  ma_in    = swap ? {fb, 3'b000} : {fa, 3'b000};
                  mb_in    = swap ? {fa, 3'b000} : {fb, 3'b000};
                  ex_in    = {2'b00, swap ? eb_e : ea_e};
                  sign_in  = swap ? sb : sa;
                  sub_in   = sa ^ sb;
                  diff_in  = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
               end
            end
         end
         S_ALIGN: begin
            // shift the smaller operand right, folding lost bits into sticky
            if (diff_ff == 5'd0) begin
               state_in = S_ADD;
            end else begin
               mb_in   = {1'b0, mb_ff[26:2], mb_ff[1] | mb_ff[0]};
               diff_in = diff_ff - 5'd1;
            end
         end
         S_ADD: begin
            if (sub_ff && (sum == 28'd0)) begin
               res_in   = 32'd0;
               state_in = S_FIN;
            end else if (sum[27]) begin
               m_in     = {1'b0, sum[27:2], sum[1] | sum[0]};
               ex_in    = ex_ff + 10'd1;
               state_in = S_NORM;
            end else begin
               m_in     = sum;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (!m_ff[26] && (ex_ff > 10'd1)) begin
               m_in  = {m_ff[26:0], 1'b0};
               ex_in = ex_ff - 10'd1;
            end else begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            res_in   = (r >= {1'b0, fsas_pkg::POS_INF}) ?
                       {sign_ff, fsas_pkg::POS_INF[30:0]} : {sign_ff, r[30:0]};
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      m_ff    <= m_in;
      ex_ff   <= ex_in;
      diff_ff <= diff_in;
      sign_ff <= sign_in;
      sub_ff  <= sub_in;
      res_ff  <= res_in;
   end

   assign done   = (state_ff == S_FIN);
   assign result = res_ff;

endmodule
`default_nettype wire
